// File: sv/lacp_pkg.sv
`default_nettype none
package lacp_pkg;

    localparam int C_WORDS = 9;
    localparam int C_ROWS  = 8;

    localparam logic [1:0] OP_TICK      = 2'd0;
    localparam logic [1:0] OP_PAT_WRITE = 2'd1;
    localparam logic [1:0] OP_LIST_WRITE = 2'd2;

    localparam logic [7:0] CMD_FRAME  = 8'd0;
    localparam logic [7:0] CMD_PERIOD = 8'd1;
    localparam logic [7:0] CMD_END    = 8'd2;

    localparam logic [7:0] LIST_END_MARK   = 8'd99;
    localparam logic [7:0] PERIOD_AT_RESET = 8'd6;

    typedef struct packed {
        logic [1:0]  operation;
        logic [3:0]  table_pattern;
        logic [5:0]  table_frame;
        logic [3:0]  table_word;
        logic [5:0]  list_index;
        logic [15:0] write_data;
    } t_cmd_word;

    typedef struct packed {
        logic [15:0] row_0;
        logic [15:0] row_1;
        logic [15:0] row_2;
        logic [15:0] row_3;
        logic [15:0] row_4;
        logic [15:0] row_5;
        logic [15:0] row_6;
        logic [15:0] row_7;
    } t_frame_word;

    typedef logic [5:0] t_step;

    typedef enum logic [4:0] {
        U_WAIT,
        U_NOP,
        U_TICK,
        U_CLR_TICK,
        U_PAT_MOD,
        U_LINE,
        U_WLINE,
        U_BASE,
        U_CMD,
        U_SET_PER,
        U_LIST_INC,
        U_LIST_ZERO,
        U_ROW_INIT,
        U_ROW_CAP,
        U_EMIT,
        U_PAT_WR,
        U_LIST_WR
    } t_uop;

    typedef enum logic [3:0] {
        J_ALWAYS,
        J_NEVER,
        J_NO_ACCEPT,
        J_OP_PWR,
        J_OP_LWR,
        J_NOT_TICK,
        J_TICK_BELOW,
        J_CMD_PERIOD,
        J_CMD_END,
        J_NOT_FRAME,
        J_NOT_MARK,
        J_NOT_ROW_LAST,
        J_OUT_BUSY,
        J_PW_BAD,
        J_LW_BAD
    } t_cond;

    typedef struct packed {
        t_uop  uop;
        logic  pat_rd;
        logic  list_rd;
        t_cond cond;
        t_step target;
    } t_ucode;

    typedef struct packed {
        logic accept;
        logic op_tick;
        logic op_pwr;
        logic op_lwr;
        logic tick_below;
        logic cmd_period;
        logic cmd_end;
        logic cmd_frame;
        logic list_mark;
        logic pw_bad;
        logic lw_bad;
        logic row_last;
        logic out_busy;
    } t_flags;

    localparam t_step S_WAIT     = 6'd0;
    localparam t_step S_DISP     = 6'd1;
    localparam t_step S_TICK     = 6'd4;
    localparam t_step S_FIRE     = 6'd6;
    localparam t_step S_DECIDE   = 6'd12;
    localparam t_step S_ROW      = 6'd15;
    localparam t_step S_ROW_RD   = 6'd16;
    localparam t_step S_EMIT     = 6'd18;
    localparam t_step S_PER      = 6'd20;
    localparam t_step S_END      = 6'd28;
    localparam t_step S_RELOAD   = 6'd32;
    localparam t_step S_PWR      = 6'd40;
    localparam t_step S_LWR      = 6'd44;

    function automatic t_ucode lacp_ucode(input t_step step);
        t_ucode w;
        unique case (step)
            S_WAIT:          w = '{U_WAIT,      1'b0, 1'b0, J_NO_ACCEPT,    S_WAIT};
            S_DISP:          w = '{U_NOP,       1'b0, 1'b0, J_OP_PWR,       S_PWR};
            S_DISP + 6'd1:   w = '{U_NOP,       1'b0, 1'b0, J_OP_LWR,       S_LWR};
            S_DISP + 6'd2:   w = '{U_NOP,       1'b0, 1'b0, J_NOT_TICK,     S_WAIT};
            S_TICK:          w = '{U_TICK,      1'b0, 1'b0, J_NEVER,        S_WAIT};
            S_TICK + 6'd1:   w = '{U_NOP,       1'b0, 1'b0, J_TICK_BELOW,   S_WAIT};
            S_FIRE:          w = '{U_CLR_TICK,  1'b0, 1'b1, J_NEVER,        S_WAIT};
            S_FIRE + 6'd1:   w = '{U_PAT_MOD,   1'b0, 1'b0, J_NEVER,        S_WAIT};
            S_FIRE + 6'd2:   w = '{U_LINE,      1'b0, 1'b0, J_NEVER,        S_WAIT};
            S_FIRE + 6'd3:   w = '{U_BASE,      1'b0, 1'b0, J_NEVER,        S_WAIT};
            S_FIRE + 6'd4:   w = '{U_NOP,       1'b1, 1'b0, J_NEVER,        S_WAIT};
            S_FIRE + 6'd5:   w = '{U_CMD,       1'b1, 1'b0, J_NEVER,        S_WAIT};
            S_DECIDE:        w = '{U_NOP,       1'b0, 1'b0, J_CMD_PERIOD,   S_PER};
            S_DECIDE + 6'd1: w = '{U_NOP,       1'b0, 1'b0, J_CMD_END,      S_END};
            S_DECIDE + 6'd2: w = '{U_NOP,       1'b0, 1'b0, J_NOT_FRAME,    S_WAIT};
            S_ROW:           w = '{U_ROW_INIT,  1'b0, 1'b0, J_NEVER,        S_WAIT};
            S_ROW_RD:        w = '{U_NOP,       1'b1, 1'b0, J_NEVER,        S_WAIT};
            S_ROW_RD + 6'd1: w = '{U_ROW_CAP,   1'b0, 1'b0, J_NOT_ROW_LAST, S_ROW_RD};
            S_EMIT:          w = '{U_EMIT,      1'b0, 1'b0, J_OUT_BUSY,     S_EMIT};
            S_EMIT + 6'd1:   w = '{U_NOP,       1'b0, 1'b0, J_ALWAYS,       S_WAIT};
            S_PER:           w = '{U_SET_PER,   1'b0, 1'b0, J_NEVER,        S_WAIT};
            S_PER + 6'd1:    w = '{U_LINE,      1'b0, 1'b0, J_NEVER,        S_WAIT};
            S_PER + 6'd2:    w = '{U_BASE,      1'b0, 1'b0, J_NEVER,        S_WAIT};
            S_PER + 6'd3:    w = '{U_NOP,       1'b1, 1'b0, J_NEVER,        S_WAIT};
            S_PER + 6'd4:    w = '{U_CMD,       1'b0, 1'b0, J_NEVER,        S_WAIT};
            S_PER + 6'd5:    w = '{U_NOP,       1'b0, 1'b0, J_CMD_END,      S_END};
            S_PER + 6'd6:    w = '{U_NOP,       1'b0, 1'b0, J_NOT_FRAME,    S_WAIT};
            S_PER + 6'd7:    w = '{U_NOP,       1'b0, 1'b0, J_ALWAYS,       S_ROW};
            S_END:           w = '{U_LIST_INC,  1'b0, 1'b0, J_NEVER,        S_WAIT};
            S_END + 6'd1:    w = '{U_NOP,       1'b0, 1'b1, J_NEVER,        S_WAIT};
            S_END + 6'd2:    w = '{U_NOP,       1'b0, 1'b0, J_NOT_MARK,     S_RELOAD};
            S_END + 6'd3:    w = '{U_LIST_ZERO, 1'b0, 1'b0, J_NEVER,        S_WAIT};
            S_RELOAD:        w = '{U_NOP,       1'b0, 1'b1, J_NEVER,        S_WAIT};
            S_RELOAD + 6'd1: w = '{U_PAT_MOD,   1'b0, 1'b0, J_NEVER,        S_WAIT};
            S_RELOAD + 6'd2: w = '{U_LINE,      1'b0, 1'b0, J_NEVER,        S_WAIT};
            S_RELOAD + 6'd3: w = '{U_BASE,      1'b0, 1'b0, J_NEVER,        S_WAIT};
            S_RELOAD + 6'd4: w = '{U_NOP,       1'b1, 1'b0, J_NEVER,        S_WAIT};
            S_RELOAD + 6'd5: w = '{U_CMD,       1'b0, 1'b0, J_NEVER,        S_WAIT};
            S_RELOAD + 6'd6: w = '{U_NOP,       1'b0, 1'b0, J_NOT_FRAME,    S_WAIT};
            S_RELOAD + 6'd7: w = '{U_NOP,       1'b0, 1'b0, J_ALWAYS,       S_ROW};
            S_PWR:           w = '{U_NOP,       1'b0, 1'b0, J_PW_BAD,       S_WAIT};
            S_PWR + 6'd1:    w = '{U_WLINE,     1'b0, 1'b0, J_NEVER,        S_WAIT};
            S_PWR + 6'd2:    w = '{U_BASE,      1'b0, 1'b0, J_NEVER,        S_WAIT};
            S_PWR + 6'd3:    w = '{U_PAT_WR,    1'b0, 1'b0, J_ALWAYS,       S_WAIT};
            S_LWR:           w = '{U_NOP,       1'b0, 1'b0, J_LW_BAD,       S_WAIT};
            S_LWR + 6'd1:    w = '{U_LIST_WR,   1'b0, 1'b0, J_ALWAYS,       S_WAIT};
            default:         w = '{U_NOP,       1'b0, 1'b0, J_ALWAYS,       S_WAIT};
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// File: sv/lacp_cmd_if.sv
`default_nettype none
interface lacp_cmd_if;
    import lacp_pkg::*;

    logic      valid;
    logic      ready;
    t_cmd_word data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// File: sv/lacp_frame_if.sv
`default_nettype none
interface lacp_frame_if;
    import lacp_pkg::*;

    logic        valid;
    logic        ready;
    t_frame_word data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// File: sv/lacp_ram.sv
`default_nettype none
module lacp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// File: sv/lacp_sequencer.sv
`default_nettype none
module lacp_sequencer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  lacp_pkg::t_flags i_flags,
    output lacp_pkg::t_ucode o_ctl
);
    import lacp_pkg::*;

    t_step  r_step;
    t_step  n_step;
    t_ucode ctl;
    logic   jump;

    assign ctl = lacp_ucode(r_step);

    always_comb begin
        unique case (ctl.cond)
            J_ALWAYS:       jump = 1'b1;
            J_NEVER:        jump = 1'b0;
            J_NO_ACCEPT:    jump = !i_flags.accept;
            J_OP_PWR:       jump = i_flags.op_pwr;
            J_OP_LWR:       jump = i_flags.op_lwr;
            J_NOT_TICK:     jump = !i_flags.op_tick;
            J_TICK_BELOW:   jump = i_flags.tick_below;
            J_CMD_PERIOD:   jump = i_flags.cmd_period;
            J_CMD_END:      jump = i_flags.cmd_end;
            J_NOT_FRAME:    jump = !i_flags.cmd_frame;
            J_NOT_MARK:     jump = !i_flags.list_mark;
            J_NOT_ROW_LAST: jump = !i_flags.row_last;
            J_OUT_BUSY:     jump = i_flags.out_busy;
            J_PW_BAD:       jump = i_flags.pw_bad;
            J_LW_BAD:       jump = i_flags.lw_bad;
            default:        jump = 1'b1;
        endcase
    end

    always_comb begin
        n_step = jump ? ctl.target : r_step + 6'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_WAIT;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_ctl = ctl;
endmodule
`default_nettype wire

// File: sv/lacp_datapath.sv
`default_nettype none
module lacp_datapath #(
    parameter int PATTERNS = 16,
    parameter int FRAMES   = 64,
    parameter int LIST_LEN = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    lacp_cmd_if.sink         i_cmd,
    lacp_frame_if.source     o_frame,
    input  lacp_pkg::t_ucode i_ctl,
    output lacp_pkg::t_flags o_flags
);
    import lacp_pkg::*;

    localparam int PW    = $clog2(PATTERNS);
    localparam int FW    = $clog2(FRAMES);
    localparam int LW    = $clog2(LIST_LEN);
    localparam int LINES = PATTERNS * FRAMES;
    localparam int LNW   = $clog2(LINES);
    localparam int DEPTH = LINES * C_WORDS;
    localparam int AW    = $clog2(DEPTH);

    t_cmd_word   r_in;
    logic [7:0]  r_tick;
    logic [7:0]  n_tick;
    logic [7:0]  r_period;
    logic [7:0]  n_period;
    logic [LW-1:0] r_list_pos;
    logic [LW-1:0] n_list_pos;
    logic [FW-1:0] r_frame;
    logic [FW-1:0] n_frame;
    logic [PW-1:0] r_pat;
    logic [LNW-1:0] r_line;
    logic [AW-1:0] r_base;
    logic [7:0]  r_cmd;
    logic [3:0]  r_widx;
    logic [2:0]  r_cnt;
    logic [15:0] r_shift [C_ROWS];
    t_frame_word r_out;
    logic        r_out_valid;
    logic        n_out_valid;

    logic          accept;
    logic          out_busy;
    logic          emit_go;
    logic [FW-1:0] frame_inc;
    logic [LW-1:0] list_inc;
    logic [15:0]   idx_wide;
    logic [AW-1:0] pat_waddr;
    logic [AW-1:0] pat_raddr;
    logic [15:0]   pat_rdata;
    logic [7:0]    list_rdata;

    function automatic logic [PW-1:0] pat_mod(input logic [7:0] v);
        logic [16:0] acc;
        logic [16:0] dv;
        acc = 17'(v);
        for (int k = 7; k >= 0; k--) begin
            dv = 17'(PATTERNS) << k;
            if (acc >= dv) begin
                acc = acc - dv;
            end
        end
        return acc[PW-1:0];
    endfunction

    assign i_cmd.ready = (i_ctl.uop == U_WAIT);
    assign accept      = i_cmd.valid && i_cmd.ready;
    assign out_busy    = r_out_valid && !o_frame.ready;
    assign emit_go     = (i_ctl.uop == U_EMIT) && !out_busy;

    assign frame_inc = (r_frame == FW'(FRAMES - 1)) ? '0 : r_frame + 1'b1;
    assign list_inc  = (r_list_pos == LW'(LIST_LEN - 1)) ? '0 : r_list_pos + 1'b1;
    assign idx_wide  = 16'(r_in.list_index);

    assign pat_waddr = r_base + AW'(r_in.table_word);
    assign pat_raddr = r_base + AW'(r_widx);

    lacp_ram #(
        .WIDTH(16),
        .DEPTH(DEPTH)
    ) u_pattern_ram (
        .i_clk  (i_clk),
        .i_we   (i_ctl.uop == U_PAT_WR),
        .i_waddr(pat_waddr),
        .i_wdata(r_in.write_data),
        .i_re   (i_ctl.pat_rd),
        .i_raddr(pat_raddr),
        .o_rdata(pat_rdata)
    );

    lacp_ram #(
        .WIDTH(8),
        .DEPTH(LIST_LEN)
    ) u_list_ram (
        .i_clk  (i_clk),
        .i_we   (i_ctl.uop == U_LIST_WR),
        .i_waddr(idx_wide[LW-1:0]),
        .i_wdata(r_in.write_data[7:0]),
        .i_re   (i_ctl.list_rd),
        .i_raddr(r_list_pos),
        .o_rdata(list_rdata)
    );

    always_comb begin
        o_flags.accept     = accept;
        o_flags.op_tick    = (r_in.operation == OP_TICK);
        o_flags.op_pwr     = (r_in.operation == OP_PAT_WRITE);
        o_flags.op_lwr     = (r_in.operation == OP_LIST_WRITE);
        o_flags.tick_below = (r_tick < r_period);
        o_flags.cmd_period = (r_cmd == CMD_PERIOD);
        o_flags.cmd_end    = (r_cmd == CMD_END);
        o_flags.cmd_frame  = (r_cmd == CMD_FRAME);
        o_flags.list_mark  = (list_rdata == LIST_END_MARK);
        o_flags.pw_bad     = (9'(r_in.table_pattern) >= 9'(PATTERNS))
                          || (9'(r_in.table_frame) >= 9'(FRAMES))
                          || (9'(r_in.table_word) >= 9'(C_WORDS));
        o_flags.lw_bad     = (9'(r_in.list_index) >= 9'(LIST_LEN));
        o_flags.row_last   = (r_cnt == 3'(C_ROWS - 1));
        o_flags.out_busy   = out_busy;
    end

    always_comb begin
        n_tick     = r_tick;
        n_period   = r_period;
        n_list_pos = r_list_pos;
        n_frame    = r_frame;
        unique case (i_ctl.uop)
            U_TICK:      n_tick = r_tick + 8'd1;
            U_CLR_TICK:  n_tick = '0;
            U_SET_PER: begin
                n_period = pat_rdata[7:0];
                n_frame  = frame_inc;
            end
            U_LIST_INC: begin
                n_list_pos = list_inc;
                n_frame    = '0;
            end
            U_LIST_ZERO: n_list_pos = '0;
            U_EMIT: begin
                if (emit_go) begin
                    n_frame = frame_inc;
                end
            end
            default: ;
        endcase
        if (emit_go) begin
            n_out_valid = 1'b1;
        end else if (o_frame.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick      <= '0;
            r_period    <= PERIOD_AT_RESET;
            r_list_pos  <= '0;
            r_frame     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_tick      <= n_tick;
            r_period    <= n_period;
            r_list_pos  <= n_list_pos;
            r_frame     <= n_frame;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_cmd.data;
        end
        if (i_ctl.pat_rd) begin
            r_widx <= r_widx + 4'd1;
        end
        unique case (i_ctl.uop)
            U_PAT_MOD: r_pat  <= pat_mod(list_rdata);
            U_LINE:    r_line <= LNW'(r_pat) * LNW'(FRAMES) + LNW'(r_frame);
            U_WLINE:   r_line <= LNW'(r_in.table_pattern) * LNW'(FRAMES)
                                 + LNW'(r_in.table_frame);
            U_BASE: begin
                r_base <= (AW'(r_line) << 3) + AW'(r_line);
                r_widx <= '0;
            end
            U_CMD:     r_cmd <= pat_rdata[7:0];
            U_ROW_INIT: begin
                r_widx <= 4'd1;
                r_cnt  <= '0;
            end
            U_ROW_CAP: begin
                for (int k = 0; k < C_ROWS - 1; k++) begin
                    r_shift[k] <= r_shift[k+1];
                end
                r_shift[C_ROWS-1] <= pat_rdata;
                r_cnt <= r_cnt + 3'd1;
            end
            default: ;
        endcase
        if (emit_go) begin
            r_out <= '{row_0: r_shift[0], row_1: r_shift[1], row_2: r_shift[2],
                       row_3: r_shift[3], row_4: r_shift[4], row_5: r_shift[5],
                       row_6: r_shift[6], row_7: r_shift[7]};
        end
    end

    assign o_frame.valid = r_out_valid;
    assign o_frame.data  = r_out;
endmodule
`default_nettype wire

// File: sv/led_animation_command_player_top.sv
// One word is taken at a time; the input is ready only while the sequencer waits.
// A tick that does not fire only counts the prescaler; one that fires reads the play list
// entry and the line command, takes a period line and then an end line first if present,
// reads eight rows via the one pattern memory read port, then emits, waiting on the output.
// Synchronous active-low reset clears the sequencer, prescaler, period (to 6) and
// positions; pattern memory and play list contents are undefined until written.
`default_nettype none
module led_animation_command_player_top #(
    parameter int PATTERNS = 16,
    parameter int FRAMES   = 64,
    parameter int LIST_LEN = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    lacp_cmd_if.sink     i_cmd,
    lacp_frame_if.source o_frame
);
    import lacp_pkg::*;

    t_ucode ctl;
    t_flags flags;

    lacp_sequencer u_sequencer (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_flags(flags),
        .o_ctl  (ctl)
    );

    lacp_datapath #(
        .PATTERNS(PATTERNS),
        .FRAMES  (FRAMES),
        .LIST_LEN(LIST_LEN)
    ) u_datapath (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (i_cmd),
        .o_frame(o_frame),
        .i_ctl  (ctl),
        .o_flags(flags)
    );

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> i_cmd.ready && !o_frame.valid)
        else $error("not idle after reset");

    a_result_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_frame.valid) |-> $past(ctl.uop == U_EMIT))
        else $error("result raised outside the emit step");

    a_emit_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctl.uop == U_EMIT) && o_frame.valid && !o_frame.ready |=> (ctl.uop == U_EMIT))
        else $error("emit step left while output busy");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctl.pat_rd || ctl.list_rd) |-> !i_cmd.ready)
        else $error("input ready during a memory read step");
endmodule
`default_nettype wire

// File: sim/led_animation_command_player_top_test.sv
module led_animation_command_player_top_test;
    import lacp_pkg::*;

    localparam int NUM_PATTERNS = 16;
    localparam int NUM_FRAMES   = 64;
    localparam int NUM_LIST     = 64;
    localparam int STORE_DEPTH  = NUM_PATTERNS * NUM_FRAMES * C_WORDS;

    localparam logic [1:0] OP_IGNORED = 2'd3;

    logic i_clk;
    logic i_rst_n;

    lacp_cmd_if   cmd_if();
    lacp_frame_if frame_if();

    led_animation_command_player_top #(
        .PATTERNS(NUM_PATTERNS),
        .FRAMES  (NUM_FRAMES),
        .LIST_LEN(NUM_LIST)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd_if),
        .o_frame(frame_if)
    );

    bit [15:0] pat_mem    [STORE_DEPTH];
    bit        pat_known  [STORE_DEPTH];
    bit [7:0]  play_list  [NUM_LIST];
    bit        list_known [NUM_LIST];
    bit [7:0]  tick_cnt;
    bit [7:0]  period_cur;
    int        list_pos;
    int        frame_pos;
    int        fire_count;
    int        gap_addr;
    int        gap_list;

    t_frame_word frames_due[$];

    int error_count;
    int src_idle_pct;
    int snk_stall_pct;

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        frame_if.ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    always @(posedge i_clk) begin
        logic [C_ROWS-1:0][15:0] want;
        logic [C_ROWS-1:0][15:0] got;
        if (i_rst_n && frame_if.valid && frame_if.ready) begin
            got = frame_if.data;
            if (frames_due.size() == 0) begin
                $error("frame word with none expected: %h", got);
                error_count++;
            end else begin
                want = frames_due.pop_front();
                for (int r = 0; r < C_ROWS; r++) begin
                    if (got[C_ROWS-1-r] !== want[C_ROWS-1-r]) begin
                        $error("row_%0d expected %h actual %h", r,
                               want[C_ROWS-1-r], got[C_ROWS-1-r]);
                        error_count++;
                    end
                end
            end
        end
    end

    function automatic int word_addr(input int lp, input int fp, input int wd);
        return ((int'(play_list[lp]) % NUM_PATTERNS) * NUM_FRAMES + fp) * C_WORDS + wd;
    endfunction

    // record the first entry a firing would read before it was ever written
    function automatic bit [15:0] peek(input int lp, input int fp, input int wd);
        int a;
        if (!list_known[lp]) begin
            if (gap_list < 0)
                gap_list = lp;
            return 16'h0;
        end
        a = word_addr(lp, fp, wd);
        if (!pat_known[a] && gap_addr < 0)
            gap_addr = a;
        return pat_mem[a];
    endfunction

    function automatic bit play_line(input bit commit, output t_frame_word rows);
        logic [C_ROWS-1:0][15:0] r;
        logic [7:0] code;
        logic [7:0] per;
        int lp;
        int fp;
        bit hit;
        lp = list_pos;
        fp = frame_pos;
        per = period_cur;
        hit = 1'b0;
        r = '0;
        gap_addr = -1;
        gap_list = -1;
        code = 8'(peek(lp, fp, 0));
        if (code == CMD_PERIOD) begin
            per = 8'(peek(lp, fp, 1));
            fp = (fp + 1) % NUM_FRAMES;
            code = 8'(peek(lp, fp, 0));
        end
        if (code == CMD_END) begin
            lp = (lp + 1) % NUM_LIST;
            fp = 0;
            if (!list_known[lp] && gap_list < 0)
                gap_list = lp;
            if (play_list[lp] == LIST_END_MARK)
                lp = 0;
            code = 8'(peek(lp, fp, 0));
        end
        if (code == CMD_FRAME) begin
            for (int i = 0; i < C_ROWS; i++)
                r[C_ROWS-1-i] = peek(lp, fp, i + 1);
            fp = (fp + 1) % NUM_FRAMES;
            hit = 1'b1;
        end
        rows = r;
        if (commit) begin
            list_pos = lp;
            frame_pos = fp;
            period_cur = per;
        end
        return hit;
    endfunction

    function automatic void apply_word(input t_cmd_word w);
        t_frame_word rows;
        int a;
        case (w.operation)
            OP_TICK: begin
                tick_cnt = tick_cnt + 8'd1;
                if (tick_cnt >= period_cur) begin
                    tick_cnt = '0;
                    fire_count++;
                    if (play_line(1'b1, rows))
                        frames_due.push_back(rows);
                end
            end
            OP_PAT_WRITE: begin
                if (w.table_word < C_WORDS) begin
                    a = (int'(w.table_pattern) * NUM_FRAMES + int'(w.table_frame)) * C_WORDS
                        + int'(w.table_word);
                    pat_mem[a] = w.write_data;
                    pat_known[a] = 1'b1;
                end
            end
            OP_LIST_WRITE: begin
                play_list[w.list_index] = w.write_data[7:0];
                list_known[w.list_index] = 1'b1;
            end
            default: ;
        endcase
    endfunction

    function automatic t_cmd_word noise_word();
        t_cmd_word w;
        w.operation     = 2'($urandom_range(3));
        w.table_pattern = 4'($urandom);
        w.table_frame   = 6'($urandom);
        w.table_word    = 4'($urandom);
        w.list_index    = 6'($urandom);
        w.write_data    = 16'($urandom);
        return w;
    endfunction

    function automatic bit [15:0] random_command();
        int pick;
        logic [7:0] code;
        pick = $urandom_range(99);
        if (pick < 60)
            code = CMD_FRAME;
        else if (pick < 75)
            code = CMD_PERIOD;
        else if (pick < 90)
            code = CMD_END;
        else
            code = 8'($urandom_range(255, 3));
        return {8'($urandom), code};
    endfunction

    function automatic bit [15:0] random_period();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70)
            return {8'($urandom), 8'($urandom_range(3))};
        else if (pick < 95)
            return {8'($urandom), 8'($urandom_range(12, 4))};
        return 16'($urandom);
    endfunction

    function automatic bit [15:0] random_entry();
        int pick;
        pick = $urandom_range(99);
        if (pick < 15)
            return {8'($urandom), LIST_END_MARK};
        else if (pick < 40)
            return {8'($urandom), 8'($urandom_range(255, NUM_PATTERNS))};
        return {8'($urandom), 8'($urandom_range(NUM_PATTERNS - 1))};
    endfunction

    task automatic send_word(input t_cmd_word w);
        while ($urandom_range(99) < src_idle_pct) begin
            cmd_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.data  <= w;
        @(posedge i_clk);
        while (!cmd_if.ready)
            @(posedge i_clk);
        apply_word(w);
    endtask

    task automatic send_pat(input int pat, input int line, input int wd, input bit [15:0] data);
        t_cmd_word w;
        w = noise_word();
        w.operation     = OP_PAT_WRITE;
        w.table_pattern = 4'(pat);
        w.table_frame   = 6'(line);
        w.table_word    = 4'(wd);
        w.write_data    = data;
        send_word(w);
    endtask

    task automatic send_list(input int idx, input bit [15:0] data);
        t_cmd_word w;
        w = noise_word();
        w.operation  = OP_LIST_WRITE;
        w.list_index = 6'(idx);
        w.write_data = data;
        send_word(w);
    endtask

    // write whatever a firing would read before it was written, then tick
    task automatic send_tick();
        t_frame_word rows;
        t_cmd_word w;
        int base;
        if (8'(tick_cnt + 8'd1) >= period_cur) begin
            void'(play_line(1'b0, rows));
            while (gap_list >= 0 || gap_addr >= 0) begin
                if (gap_list >= 0) begin
                    send_list(gap_list, random_entry());
                end else begin
                    base = gap_addr - gap_addr % C_WORDS;
                    for (int k = 0; k < C_WORDS; k++) begin
                        if (!pat_known[base + k])
                            send_pat(base / C_WORDS / NUM_FRAMES, (base / C_WORDS) % NUM_FRAMES,
                                     k, k == 0 ? random_command() :
                                        k == 1 ? random_period() : 16'($urandom));
                    end
                end
                void'(play_line(1'b0, rows));
            end
        end
        w = noise_word();
        w.operation = OP_TICK;
        send_word(w);
    endtask

    task automatic tick_until_fired(input int n);
        int target;
        target = fire_count + n;
        while (fire_count < target)
            send_tick();
    endtask

    task automatic test_directed_play();
        t_cmd_word w;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        send_list(0, 16'hFF2F);
        send_list(1, 16'h0063);
        w = noise_word();
        w.operation = OP_IGNORED;
        send_word(w);
        send_pat(15, 0, 9, 16'hFFFF);
        send_pat(15, 0, 0, 16'h0101);
        send_pat(15, 0, 1, 16'hAB00);
        send_pat(15, 1, 0, 16'hFF00);
        send_pat(15, 1, 1, 16'hFFFF);
        send_pat(15, 1, 2, 16'h0000);
        send_pat(15, 1, 3, 16'h8001);
        send_pat(15, 1, 4, 16'h7FFE);
        send_pat(15, 1, 5, 16'hAAAA);
        send_pat(15, 1, 6, 16'h5555);
        send_pat(15, 1, 7, 16'h0F0F);
        send_pat(15, 1, 8, 16'hF0F0);
        send_pat(15, 2, 0, 16'h3C02);
        repeat (8)
            send_tick();
    endtask

    // mostly period lines so one pass over every line stays cheap
    task automatic test_line_wrap();
        int pat;
        src_idle_pct  = 58;
        snk_stall_pct = 0;
        pat = int'(play_list[list_pos]) % NUM_PATTERNS;
        for (int line = 0; line < NUM_FRAMES; line++) begin
            if (line % 8 == 3) begin
                send_pat(pat, line, 0, {8'($urandom), CMD_FRAME});
                for (int k = 1; k < C_WORDS; k++)
                    send_pat(pat, line, k, 16'($urandom));
            end else begin
                send_pat(pat, line, 0, {8'($urandom), CMD_PERIOD});
                send_pat(pat, line, 1, {8'($urandom), 8'h00});
            end
        end
        tick_until_fired(NUM_FRAMES + 6);
    endtask

    // every entry points at one pattern whose lines end at once
    task automatic test_list_wrap();
        int pat;
        bit [7:0] entry;
        src_idle_pct  = 0;
        snk_stall_pct = 58;
        pat = $urandom_range(NUM_PATTERNS - 1);
        for (int idx = 0; idx < NUM_LIST; idx++) begin
            entry = 8'(pat + NUM_PATTERNS * $urandom_range(15));
            if (entry == LIST_END_MARK)
                entry = 8'(pat);
            send_list(idx, {8'($urandom), entry});
        end
        send_pat(pat, 0, 0, {8'($urandom), CMD_END});
        send_pat(pat, frame_pos, 0, {8'($urandom), CMD_END});
        tick_until_fired(NUM_LIST + 6);
    endtask

    task automatic test_random_traffic(input int idle, input int stall, input int count);
        t_cmd_word w;
        int n;
        int pick;
        int wd;
        src_idle_pct  = idle;
        snk_stall_pct = stall;
        n = 0;
        while (n < count) begin
            pick = $urandom_range(99);
            if (pick < 62) begin
                send_tick();
                n++;
            end else if (pick < 80) begin
                wd = $urandom_range(C_WORDS - 1);
                send_pat(int'(play_list[list_pos]) % NUM_PATTERNS,
                         (frame_pos + $urandom_range(3)) % NUM_FRAMES, wd,
                         wd == 0 ? random_command() : wd == 1 ? random_period() : 16'($urandom));
                n++;
            end else if (pick < 88) begin
                send_list($urandom_range(1) ? (list_pos + $urandom_range(2)) % NUM_LIST
                                            : $urandom_range(NUM_LIST - 1), random_entry());
                n++;
            end else if (pick < 94) begin
                wd = $urandom_range(C_WORDS - 1);
                send_pat($urandom_range(NUM_PATTERNS - 1), $urandom_range(NUM_FRAMES - 1), wd,
                         wd == 0 ? random_command() : 16'($urandom));
                n++;
            end else begin
                // drop: unused operation or word past the line
                w = noise_word();
                if ($urandom_range(1)) begin
                    w.operation = OP_IGNORED;
                end else begin
                    w.operation  = OP_PAT_WRITE;
                    w.table_word = 4'($urandom_range(15, C_WORDS));
                end
                send_word(w);
            end
        end
    endtask

    initial begin
        int n;
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        cmd_if.valid  = 1'b0;
        cmd_if.data   = '0;
        frame_if.ready = 1'b0;
        error_count   = 0;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        tick_cnt      = '0;
        period_cur    = PERIOD_AT_RESET;
        list_pos      = 0;
        frame_pos     = 0;
        fire_count    = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_play();
        test_line_wrap();
        test_list_wrap();
        test_random_traffic(0, 0, 250);
        test_random_traffic(58, 0, 250);
        test_random_traffic(0, 58, 250);
        test_random_traffic(21, 21, 250);

        cmd_if.valid <= 1'b0;
        for (n = 0; n < 20000 && frames_due.size() != 0; n++)
            @(posedge i_clk);
        repeat (64) @(posedge i_clk);
        if (frames_due.size() != 0) begin
            $error("%0d frame words never arrived", frames_due.size());
            error_count++;
        end

        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #4000000;
        $display("simulation failed");
        $finish;
    end

endmodule
